// ===== rtl/core/gas_pkg.sv =====
`timescale 1ns / 1ps
package gas_pkg;

  localparam int NODES_DEF      = 1024;
  localparam int MAX_DEGREE_DEF = 16;
  localparam int QDEPTH         = 2;

  localparam int NODE_W = 11;
  localparam int ROW_W  = 10;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_SWAP  = 2'd2;
  localparam logic [1:0] KIND_ROW   = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_QUERY,
    OP_SWAP,
    OP_ROW,
    OP_BAD
  } op_t;

  // classified command, front to back
  typedef struct packed {
    op_t               op;
    logic [NODE_W-1:0] na;
    logic [NODE_W-1:0] nb;
    logic [ROW_W-1:0]  ri;
    logic              na_ok;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_ADD2,
    ST_SW2,
    ST_SCAN
  } state_t;

endpackage

// ===== rtl/core/gas_front.sv =====
`timescale 1ns / 1ps
module gas_front #(
  parameter int NODES = gas_pkg::NODES_DEF
) (
  input  logic [1:0]                 kind,
  input  logic [gas_pkg::NODE_W-1:0] node_a,
  input  logic [gas_pkg::NODE_W-1:0] node_b,
  input  logic [gas_pkg::ROW_W-1:0]  row_index,
  output gas_pkg::cmd_t              cmd
);

  logic na_ok, nb_ok, ri_ok;

  assign na_ok = (node_a != '0) && (32'(node_a) <= NODES);
  assign nb_ok = (node_b != '0) && (32'(node_b) <= NODES);
  assign ri_ok = 32'(row_index) < NODES;

  always_comb begin
    cmd.na    = node_a;
    cmd.nb    = node_b;
    cmd.ri    = row_index;
    cmd.na_ok = na_ok;
    case (kind)
      gas_pkg::KIND_ROW:   cmd.op = ri_ok ? gas_pkg::OP_ROW : gas_pkg::OP_BAD;
      gas_pkg::KIND_ADD:   cmd.op = (na_ok && nb_ok) ? gas_pkg::OP_ADD : gas_pkg::OP_BAD;
      gas_pkg::KIND_QUERY: cmd.op = (na_ok && nb_ok) ? gas_pkg::OP_QUERY : gas_pkg::OP_BAD;
      gas_pkg::KIND_SWAP:  cmd.op = (na_ok && nb_ok) ? gas_pkg::OP_SWAP : gas_pkg::OP_BAD;
      default:             cmd.op = gas_pkg::OP_BAD;
    endcase
  end

endmodule

// ===== rtl/core/gas_queue.sv =====
`timescale 1ns / 1ps
module gas_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gas_pkg::cmd_t push_data,
  input  logic          pop,
  output gas_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  localparam int PW = (gas_pkg::QDEPTH > 1) ? $clog2(gas_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(gas_pkg::QDEPTH + 1);

  gas_pkg::cmd_t  slot_r [gas_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  assign empty = (count_r == '0);
  assign full  = (32'(count_r) == gas_pkg::QDEPTH);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (32'(wr_ptr_r) == gas_pkg::QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      if (pop)
        rd_ptr_r <= (32'(rd_ptr_r) == gas_pkg::QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== rtl/core/gas_back.sv =====
`timescale 1ns / 1ps
module gas_back #(
  parameter int NODES      = gas_pkg::NODES_DEF,
  parameter int MAX_DEGREE = gas_pkg::MAX_DEGREE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gas_pkg::cmd_t              head,
  input  logic                       empty,
  output logic                       pop,
  output logic                       clearing,
  output logic                       out_strobe,
  output logic [1:0]                 out_status,
  output logic                       out_edge_found,
  output logic [4:0]                 out_degree_of_a,
  output logic [gas_pkg::ROW_W-1:0]  out_row_of_a,
  output logic [gas_pkg::NODE_W-1:0] out_node_at_row,
  output logic [13:0]                out_edge_total
);

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int AW = (NODES * MAX_DEGREE > 1) ? $clog2(NODES * MAX_DEGREE) : 1;
  localparam int NDW = gas_pkg::NODE_W;

  // stores; adjacency is kept per node, so a swap only remaps
  logic [NDW-1:0] adj_mem [NODES * MAX_DEGREE];
  logic [DW-1:0]  deg_mem [NODES];
  logic [NW-1:0]  n2r_mem [NODES];
  logic [NDW-1:0] r2n_mem [NODES];

  gas_pkg::state_t state_r, state_nxt;
  gas_pkg::cmd_t   cur_r;
  logic [NW-1:0]   a_r, b_r;
  logic [NW-1:0]   clr_r, clr_nxt;
  logic [DW-1:0]   cnt_r, cnt_nxt;
  logic            pend_r, pend_nxt;
  logic            found_r, found_nxt;
  logic [13:0]     edge_r, edge_nxt;

  logic [DW-1:0]   deg_a_q, deg_b_q;
  logic [NW-1:0]   n2r_a_q, n2r_b_q;
  logic [NDW-1:0]  r2n_q, adj_q;

  logic [NW-1:0]   rd_a, rd_b, rd_r;
  logic [AW-1:0]   adj_raddr;

  logic            adj_we, deg_we, n2r_we, r2n_we;
  logic [AW-1:0]   adj_waddr;
  logic [NDW-1:0]  adj_wdata, r2n_wdata;
  logic [NW-1:0]   deg_waddr, n2r_waddr, n2r_wdata, r2n_waddr;
  logic [DW-1:0]   deg_wdata;

  logic            self_loop, fits;
  logic [DW-1:0]   db_eff;

  logic            ov_nxt;
  logic [1:0]      os_nxt;
  logic            of_nxt;
  logic [4:0]      od_nxt;
  logic [gas_pkg::ROW_W-1:0] orow_nxt;
  logic [NDW-1:0]  onode_nxt;

  assign clearing  = (state_r == gas_pkg::ST_CLEAR);
  assign self_loop = (a_r == b_r);
  assign fits      = self_loop ? (32'(deg_a_q) + 2 <= MAX_DEGREE)
                               : ((32'(deg_a_q) < MAX_DEGREE) && (32'(deg_b_q) < MAX_DEGREE));
  assign db_eff    = self_loop ? deg_a_q + 1'b1 : deg_b_q;

  // node addresses follow the head on a pop, then stay on the running command
  always_comb begin
    rd_a = pop ? NW'(head.na - 1'b1) : a_r;
    rd_b = pop ? NW'(head.nb - 1'b1) : b_r;
    rd_r = NW'(head.ri);
  end

  assign adj_raddr = AW'(a_r) * AW'(MAX_DEGREE) + AW'(cnt_r);

  always_ff @(posedge clk) begin
    deg_a_q <= deg_mem[rd_a];
    deg_b_q <= deg_mem[rd_b];
    n2r_a_q <= n2r_mem[rd_a];
    n2r_b_q <= n2r_mem[rd_b];
    r2n_q   <= r2n_mem[rd_r];
    adj_q   <= adj_mem[adj_raddr];
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    if (n2r_we) n2r_mem[n2r_waddr] <= n2r_wdata;
    if (r2n_we) r2n_mem[r2n_waddr] <= r2n_wdata;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
      a_r   <= rd_a;
      b_r   <= rd_b;
    end
    out_status      <= os_nxt;
    out_edge_found  <= of_nxt;
    out_degree_of_a <= od_nxt;
    out_row_of_a    <= orow_nxt;
    out_node_at_row <= onode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= gas_pkg::ST_CLEAR;
      clr_r      <= '0;
      cnt_r      <= '0;
      pend_r     <= 1'b0;
      found_r    <= 1'b0;
      edge_r     <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      cnt_r      <= cnt_nxt;
      pend_r     <= pend_nxt;
      found_r    <= found_nxt;
      edge_r     <= edge_nxt;
      out_strobe <= ov_nxt;
    end
  end

  assign out_edge_total = edge_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = 1'b0;
    found_nxt = found_r;
    edge_nxt  = edge_r;
    pop       = 1'b0;
    adj_we = 1'b0; adj_waddr = AW'(a_r) * AW'(MAX_DEGREE) + AW'(deg_a_q);
    adj_wdata = cur_r.nb;
    deg_we = 1'b0; deg_waddr = a_r; deg_wdata = deg_a_q + 1'b1;
    n2r_we = 1'b0; n2r_waddr = a_r; n2r_wdata = n2r_b_q;
    r2n_we = 1'b0; r2n_waddr = n2r_b_q; r2n_wdata = cur_r.na;
    ov_nxt    = 1'b0;
    os_nxt    = gas_pkg::STATUS_OK;
    of_nxt    = 1'b0;
    od_nxt    = cur_r.na_ok ? 5'(deg_a_q) : 5'd0;
    orow_nxt  = cur_r.na_ok ? gas_pkg::ROW_W'(n2r_a_q) : '0;
    onode_nxt = '0;
    case (state_r)
      gas_pkg::ST_CLEAR: begin
        deg_we = 1'b1; deg_waddr = clr_r; deg_wdata = '0;
        n2r_we = 1'b1; n2r_waddr = clr_r; n2r_wdata = clr_r;
        r2n_we = 1'b1; r2n_waddr = clr_r; r2n_wdata = NDW'(clr_r) + 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == NODES - 1) state_nxt = gas_pkg::ST_IDLE;
      end
      gas_pkg::ST_IDLE: begin
        if (!empty) begin
          pop       = 1'b1;
          state_nxt = gas_pkg::ST_EXEC;
        end
      end
      gas_pkg::ST_EXEC: begin
        case (cur_r.op)
          gas_pkg::OP_BAD: begin
            ov_nxt = 1'b1; os_nxt = gas_pkg::STATUS_RANGE;
            state_nxt = gas_pkg::ST_IDLE;
          end
          gas_pkg::OP_ROW: begin
            ov_nxt = 1'b1; onode_nxt = r2n_q;
            state_nxt = gas_pkg::ST_IDLE;
          end
          gas_pkg::OP_QUERY: begin
            cnt_nxt = '0; found_nxt = 1'b0;
            state_nxt = gas_pkg::ST_SCAN;
          end
          gas_pkg::OP_ADD: begin
            if (!fits) begin
              ov_nxt = 1'b1; os_nxt = gas_pkg::STATUS_FULL;
              state_nxt = gas_pkg::ST_IDLE;
            end else begin
              adj_we = 1'b1; deg_we = 1'b1;
              state_nxt = gas_pkg::ST_ADD2;
            end
          end
          gas_pkg::OP_SWAP: begin
            if (self_loop) begin
              ov_nxt = 1'b1;
              state_nxt = gas_pkg::ST_IDLE;
            end else begin
              n2r_we = 1'b1; r2n_we = 1'b1;
              state_nxt = gas_pkg::ST_SW2;
            end
          end
          default: state_nxt = gas_pkg::ST_IDLE;
        endcase
      end
      gas_pkg::ST_ADD2: begin
        // second endpoint; a self-loop takes the next slot
        adj_we = 1'b1;
        adj_waddr = AW'(b_r) * AW'(MAX_DEGREE) + AW'(db_eff);
        adj_wdata = cur_r.na;
        deg_we = 1'b1; deg_waddr = b_r; deg_wdata = db_eff + 1'b1;
        edge_nxt = edge_r + 1'b1;
        ov_nxt = 1'b1;
        od_nxt = self_loop ? 5'(deg_a_q + 2'd2) : 5'(deg_a_q + 1'b1);
        state_nxt = gas_pkg::ST_IDLE;
      end
      gas_pkg::ST_SW2: begin
        n2r_we = 1'b1; n2r_waddr = b_r; n2r_wdata = n2r_a_q;
        r2n_we = 1'b1; r2n_waddr = n2r_a_q; r2n_wdata = cur_r.nb;
        ov_nxt = 1'b1;
        orow_nxt = gas_pkg::ROW_W'(n2r_b_q);
        state_nxt = gas_pkg::ST_IDLE;
      end
      gas_pkg::ST_SCAN: begin
        if (pend_r && adj_q == cur_r.nb) found_nxt = 1'b1;
        if (cnt_r < deg_a_q) begin
          pend_nxt = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end else if (!pend_r) begin
          ov_nxt = 1'b1; of_nxt = found_r;
          state_nxt = gas_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gas_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) != gas_pkg::ST_CLEAR && $past(state_r) != gas_pkg::ST_IDLE))
    else $error("result strobe from a non-working state");
  a_edge_step: assert property (@(posedge clk) disable iff (!rst_n)
    (edge_r != $past(edge_r)) |-> (edge_r == $past(edge_r) + 14'd1 && out_strobe))
    else $error("edge count moved without a completed add");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gas_pkg::ST_SCAN) |-> (cnt_r <= deg_a_q))
    else $error("scan ran past the row degree");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == gas_pkg::ST_EXEC))
    else $error("command taken outside idle");
`endif

endmodule

// ===== rtl/core/graph_adjacency_store_top.sv =====
`timescale 1ns / 1ps
// Flow: a transfer enters the queue, the back end pops it in idle and runs it; the result is registered onto
//   the strobe; a fitting add or two-node swap takes a second state, query scans node_a's row one slot a cycle.
// Occupancy: the back end runs one command at a time and pops no new one until it has finished
//   the last; a 2-entry queue takes more transfers meanwhile.
// Reset: synchronous, active low; then a clearing pass over every node sets degrees to zero
//   and node n to row n-1, busy high throughout. Results cannot be stalled.
module graph_adjacency_store_top #(
  parameter int NODES      = gas_pkg::NODES_DEF,
  parameter int MAX_DEGREE = gas_pkg::MAX_DEGREE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_kind,
  input  logic [gas_pkg::NODE_W-1:0] in_node_a,
  input  logic [gas_pkg::NODE_W-1:0] in_node_b,
  input  logic [gas_pkg::ROW_W-1:0]  in_row_index,
  output logic                       out_strobe,
  output logic [1:0]                 out_status,
  output logic                       out_edge_found,
  output logic [4:0]                 out_degree_of_a,
  output logic [gas_pkg::ROW_W-1:0]  out_row_of_a,
  output logic [gas_pkg::NODE_W-1:0] out_node_at_row,
  output logic [13:0]                out_edge_total
);

  gas_pkg::cmd_t cmd, head;
  logic          q_empty, q_full, pop, clearing, push;

  // front: range checks and op classification, straight into the queue
  gas_front #(.NODES(NODES)) u_front (
    .kind      (in_kind),
    .node_a    (in_node_a),
    .node_b    (in_node_b),
    .row_index (in_row_index),
    .cmd       (cmd)
  );

  // a transfer is refused while the queue is full or the stores are being cleared
  assign busy = q_full || clearing;
  assign push = start && !busy;

  gas_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cmd),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // back: sequencer over the degree, map and adjacency memories
  gas_back #(.NODES(NODES), .MAX_DEGREE(MAX_DEGREE)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .empty           (q_empty),
    .pop             (pop),
    .clearing        (clearing),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_edge_found  (out_edge_found),
    .out_degree_of_a (out_degree_of_a),
    .out_row_of_a    (out_row_of_a),
    .out_node_at_row (out_node_at_row),
    .out_edge_total  (out_edge_total)
  );

endmodule

// ===== verif/graph_adjacency_store_top_test.sv =====
`timescale 1ns / 1ps
module graph_adjacency_store_top_test;

  localparam int NODES = gas_pkg::NODES_DEF;
  localparam int MAXD  = gas_pkg::MAX_DEGREE_DEF;
  localparam int LIMIT = 2_000_000;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [gas_pkg::NODE_W-1:0] na;
    logic [gas_pkg::NODE_W-1:0] nb;
    logic [gas_pkg::ROW_W-1:0]  ri;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic                       found;
    logic [4:0]                 deg;
    logic [gas_pkg::ROW_W-1:0]  row;
    logic [gas_pkg::NODE_W-1:0] at_row;
    logic [13:0]                total;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = '0;
  logic [gas_pkg::NODE_W-1:0] in_node_a = '0;
  logic [gas_pkg::NODE_W-1:0] in_node_b = '0;
  logic [gas_pkg::ROW_W-1:0] in_row_index = '0;
  logic out_strobe;
  logic [1:0] out_status;
  logic out_edge_found;
  logic [4:0] out_degree_of_a;
  logic [gas_pkg::ROW_W-1:0] out_row_of_a;
  logic [gas_pkg::NODE_W-1:0] out_node_at_row;
  logic [13:0] out_edge_total;

  graph_adjacency_store_top dut (.*);

  // shadow copy of the graph
  logic [gas_pkg::NODE_W-1:0] sh_rows [NODES*MAXD];
  int unsigned sh_deg [NODES];
  int unsigned sh_n2r [NODES];
  int unsigned sh_r2n [NODES];
  int unsigned sh_edges;

  cmd_item_t pending[$];
  reply_t    replies_due[$];
  int  mismatches = 0;
  int  cycles = 0;
  int  sent = 0;
  int  got = 0;
  int  n_full = 0;
  int  n_found = 0;
  bit  calm = 1'b0;   // no idling from the sender during this window
  bit  hold = 1'b0;   // sender paused until the store drains

  function automatic bit node_valid(logic [gas_pkg::NODE_W-1:0] n);
    return n >= 1 && n <= NODES;
  endfunction

  function automatic reply_t graph_apply(cmd_item_t c);
    reply_t r;
    int unsigned a, b, ba, bb, oa, ob;
    logic [gas_pkg::NODE_W-1:0] tmp;
    r = '0;
    a = c.na - 1;
    b = c.nb - 1;
    if (c.kind == gas_pkg::KIND_ROW) begin
      if (c.ri < NODES) r.at_row = gas_pkg::NODE_W'(sh_r2n[c.ri]);
      else r.status = gas_pkg::STATUS_RANGE;
    end else if (!node_valid(c.na) || !node_valid(c.nb)) begin
      r.status = gas_pkg::STATUS_RANGE;
    end else if (c.kind == gas_pkg::KIND_ADD) begin
      if (a == b ? sh_deg[a] + 2 > MAXD : (sh_deg[a] >= MAXD || sh_deg[b] >= MAXD)) begin
        r.status = gas_pkg::STATUS_FULL;
      end else begin
        sh_rows[sh_n2r[a]*MAXD + sh_deg[a]] = c.nb;
        sh_deg[a]++;
        sh_rows[sh_n2r[b]*MAXD + sh_deg[b]] = c.na;
        sh_deg[b]++;
        sh_edges++;
      end
    end else if (c.kind == gas_pkg::KIND_QUERY) begin
      for (int i = 0; i < sh_deg[a]; i++)
        if (sh_rows[sh_n2r[a]*MAXD + i] == c.nb) r.found = 1'b1;
    end else if (a != b) begin
      oa = sh_n2r[a];
      ob = sh_n2r[b];
      for (int i = 0; i < MAXD; i++) begin
        ba = oa*MAXD + i;
        bb = ob*MAXD + i;
        tmp = sh_rows[ba];
        sh_rows[ba] = sh_rows[bb];
        sh_rows[bb] = tmp;
      end
      sh_n2r[a] = ob;
      sh_r2n[ob] = c.na;
      sh_n2r[b] = oa;
      sh_r2n[oa] = c.nb;
    end
    if (node_valid(c.na)) begin
      r.deg = 5'(sh_deg[a]);
      r.row = gas_pkg::ROW_W'(sh_n2r[a]);
    end
    r.total = 14'(sh_edges);
    return r;
  endfunction

  function automatic cmd_item_t mk(logic [1:0] k, int x, int y, int ri);
    cmd_item_t c;
    c.kind = k;
    c.na = gas_pkg::NODE_W'(x);
    c.nb = gas_pkg::NODE_W'(y);
    c.ri = gas_pkg::ROW_W'(ri);
    return c;
  endfunction

  // random node, mostly from a small pool so rows fill and queries hit
  function automatic int pick_node();
    int s;
    s = $urandom_range(0, 99);
    if (s < 70) return $urandom_range(1, 24);
    if (s < 92) return $urandom_range(1, NODES);
    if (s < 96) return 0;
    return $urandom_range(NODES + 1, 2047);
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // driver: a transfer happens on an edge with start high and busy low
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (start && !busy) begin
        replies_due.push_back(graph_apply(pending.pop_front()));
        sent <= sent + 1;
      end
      if (start && busy) begin
        // hold the current command
      end else if (pending.size() > 0 && !hold && (calm || $urandom_range(0, 99) >= 32)) begin
        // peek only: the entry is consumed once its transfer is seen
        start        <= 1'b1;
        in_kind      <= pending[0].kind;
        in_node_a    <= pending[0].na;
        in_node_b    <= pending[0].nb;
        in_row_index <= pending[0].ri;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobe is one result transfer
  always @(posedge clk) begin
    reply_t act, exp_r;
    if (rst_n && out_strobe) begin
      act = {out_status, out_edge_found, out_degree_of_a, out_row_of_a,
             out_node_at_row, out_edge_total};
      got <= got + 1;
      if (replies_due.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", act);
      end else begin
        exp_r = replies_due.pop_front();
        if (exp_r.status == gas_pkg::STATUS_FULL) n_full <= n_full + 1;
        if (exp_r.found) n_found <= n_found + 1;
        if (act !== exp_r) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch at cycle %0d: expected %p, got %p", cycles, exp_r, act);
        end
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("timeout with %0d results outstanding", replies_due.size());
      $display("graph_adjacency_store_top_test: FAIL");
      $finish;
    end
  end

  initial begin
    int k;
    int x;
    for (int i = 0; i < NODES; i++) begin
      sh_deg[i] = 0;
      sh_n2r[i] = i;
      sh_r2n[i] = i + 1;
    end
    for (int i = 0; i < NODES*MAXD; i++) sh_rows[i] = '0;
    sh_edges = 0;

    // directed: extremes, range errors, self-loops, swaps, full rows
    pending.push_back(mk(gas_pkg::KIND_ROW, 0, 0, 0));
    pending.push_back(mk(gas_pkg::KIND_ROW, 2047, 0, 1023));
    pending.push_back(mk(gas_pkg::KIND_ADD, 1, NODES, 0));
    pending.push_back(mk(gas_pkg::KIND_QUERY, NODES, 1, 0));
    pending.push_back(mk(gas_pkg::KIND_QUERY, 1, 2, 0));
    pending.push_back(mk(gas_pkg::KIND_ADD, 0, 5, 0));
    pending.push_back(mk(gas_pkg::KIND_ADD, 5, 2047, 0));
    pending.push_back(mk(gas_pkg::KIND_QUERY, NODES + 1, 3, 0));
    pending.push_back(mk(gas_pkg::KIND_SWAP, 0, 3, 0));
    pending.push_back(mk(gas_pkg::KIND_ADD, 7, 7, 1023));
    pending.push_back(mk(gas_pkg::KIND_QUERY, 7, 7, 0));
    pending.push_back(mk(gas_pkg::KIND_ADD, 1, NODES, 0));
    pending.push_back(mk(gas_pkg::KIND_SWAP, 1, NODES, 0));
    pending.push_back(mk(gas_pkg::KIND_ROW, 0, 0, 0));
    pending.push_back(mk(gas_pkg::KIND_ROW, 0, 0, NODES - 1));
    pending.push_back(mk(gas_pkg::KIND_QUERY, NODES, 1, 0));
    pending.push_back(mk(gas_pkg::KIND_SWAP, 7, 7, 0));
    // fill node 9 to full with self-loops, then the next two adds to it must be refused
    for (int i = 0; i < 8; i++) pending.push_back(mk(gas_pkg::KIND_ADD, 9, 9, 0));
    pending.push_back(mk(gas_pkg::KIND_ADD, 9, 10, 0));
    pending.push_back(mk(gas_pkg::KIND_ADD, 10, 9, 0));
    pending.push_back(mk(gas_pkg::KIND_ADD, 7, 7, 0));

    // random body; most traffic on a small node pool
    for (int i = 0; i < 1800; i++) begin
      k = $urandom_range(0, 99);
      if (k < 40)
        pending.push_back(mk(gas_pkg::KIND_ADD, pick_node(), pick_node(), $urandom));
      else if (k < 70)
        pending.push_back(mk(gas_pkg::KIND_QUERY, pick_node(), pick_node(), $urandom));
      else if (k < 85)
        pending.push_back(mk(gas_pkg::KIND_SWAP, pick_node(), pick_node(), $urandom));
      else begin
        x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 30);
        pending.push_back(mk(gas_pkg::KIND_ROW, $urandom, $urandom, x));
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // a stretch of back-to-back commands, then one drain pause
    wait (sent >= 300);
    @(posedge clk);
    calm <= 1'b1;
    wait (sent >= 700);
    @(posedge clk);
    calm <= 1'b0;
    hold <= 1'b1;
    wait (!start && replies_due.size() == 0);
    repeat (5) @(posedge clk);
    hold <= 1'b0;

    wait (pending.size() == 0 && replies_due.size() == 0);
    repeat (50) @(posedge clk);
    $display("%0d commands sent, %0d results checked", sent, got);
    $display("%0d refused for full rows, %0d queries found an edge", n_full, n_found);
    if (mismatches == 0) begin
      $display("graph_adjacency_store_top_test: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("graph_adjacency_store_top_test: FAIL");
    end
    $finish;
  end

endmodule
